FILE: design/gtr_pkg.sv
// Shared types and constants for the grid treasure reachability block.
`default_nettype none

package gtr_pkg;

  localparam int DIM_W   = 7;   // grid_rows / grid_cols register width
  localparam int START_W = 6;   // start_row / start_col register width
  localparam int KIND_W  = 2;   // cell code width
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 8;

  localparam logic [KIND_W-1:0] KIND_WALL     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TREASURE = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_ROWS = 2'd0,
    REG_GRID_COLS = 2'd1,
    REG_START_ROW = 2'd2,
    REG_START_COL = 2'd3
  } reg_idx_t;

  // controller -> datapath
  typedef struct packed {
    logic cfg_wr;     // take the config write
    logic load;       // store the incoming cell
    logic div_init;   // start recomputing row/col of the load position
    logic div_step;   // one quotient bit
    logic clr_step;   // clear one visited entry
    logic srch_init;  // push the start cell
    logic top_rd;     // read top cell kind, mark it visited, restart direction
    logic nb_rd;      // read kind and visited of the current neighbor
    logic dir_next;   // advance to the next direction
    logic mark_nb;    // mark current neighbor visited (wall)
    logic push;       // push current neighbor
    logic pop;        // drop top, fetch the one below
    logic pop_fill;   // load fetched entry as top
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic load_last;  // next cell completes the grid
    logic div_done;
    logic clr_last;   // last entry of the clear sweep
    logic top_treas;  // top cell is a treasure
    logic nb_in;      // neighbor in current direction is inside the grid
    logic dir_last;   // current direction is the last one
    logic nb_vis;     // neighbor already visited
    logic nb_wall;    // neighbor is a wall
    logic depth_one;  // stack holds only the top entry
  } sts_t;

endpackage

`default_nettype wire

FILE: design/grid_treasure_reachability.sv
// Top level: grid treasure reachability, controller plus datapath.
// Usage:
//  - Cells stream in on in_* in raster order, one request per cell, coded
//    0 open, 1 wall, 2 treasure (3 counts as open). A cell is taken each
//    cycle while loading unless a config write or a pending result stalls it.
//  - Once rows*cols cells are in, the visited map of the grid in use is
//    cleared and a depth-first search runs from the start cell. Each
//    visit reads the top cell and marks it visited, then examines its
//    in-grid neighbors in turn; a backtrack pops the stack and fetches
//    the entry below as the new top.
//  - One result request per grid leaves on out_*: bit 0 says whether a
//    treasure is reachable. in_tready stays low during clear and search.
//  - A stalled result does not block loading the next grid; only its last
//    cell waits until out_tready takes the pending result.
//  - cfg_* writes rows, cols, start row, start col (index 0..3). After each
//    write cfg_ready and in_tready stay low while the load position is
//    recomputed with a bit-serial divide.
//  - rst_n (synchronous) sets rows=cols=1, start=0,0 and drops any
//    partial grid; the cell store holds no defined contents after reset.
`default_nettype none

module grid_treasure_reachability #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // in_tdata: [1:0] cell_kind, rest zero
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [gtr_pkg::IN_TDATA_W-1:0]      in_tdata,
  // out_tdata: [0] treasure_reachable, rest zero
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [gtr_pkg::OUT_TDATA_W-1:0]          out_tdata,
  // configuration writes
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [gtr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [gtr_pkg::CFG_DATA_W-1:0]      cfg_data
);

  gtr_pkg::cmd_t cmd;
  gtr_pkg::sts_t sts;
  logic          res;

  gtr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .out_valid  (out_tvalid),
    .out_res    (res),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  gtr_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cell_kind (in_tdata[gtr_pkg::KIND_W-1:0]),
    .cmd       (cmd),
    .sts       (sts)
  );

  assign out_tdata = {{(gtr_pkg::OUT_TDATA_W-1){1'b0}}, res};

endmodule

`default_nettype wire

FILE: design/gtr_dp.sv
// Datapath: config registers, cell/visited/stack memories, load and search registers.
`default_nettype none

module gtr_dp #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic [gtr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [gtr_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic [gtr_pkg::KIND_W-1:0]       cell_kind,
  input  wire gtr_pkg::cmd_t                    cmd,
  output gtr_pkg::sts_t                         sts
);

  localparam int DIM_W  = gtr_pkg::DIM_W;
  localparam int RW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int AW     = RW + CW;
  localparam int CELLS  = 2 ** AW;
  localparam int SDW    = AW + 1;
  localparam int LCW0   = $clog2(MAX_ROWS * MAX_COLS + 1);
  localparam int LCW    = (LCW0 < 2) ? 2 : LCW0;
  localparam int DIVCW  = $clog2(LCW + 1);
  localparam int XW0    = (RW > CW) ? RW : CW;
  localparam int XW     = ((XW0 > DIM_W) ? XW0 : DIM_W) + 1;

  typedef enum logic [1:0] {
    DIR_RIGHT = 2'd0,
    DIR_LEFT  = 2'd1,
    DIR_UP    = 2'd2,
    DIR_DOWN  = 2'd3
  } dir_t;

  // config
  logic [DIM_W-1:0]             grid_rows_r, grid_cols_r;
  logic [gtr_pkg::START_W-1:0]  start_row_r, start_col_r;
  logic [DIM_W-1:0]             rows_c, cols_c;
  logic [LCW-1:0]               total_r;

  // load position
  logic [LCW-1:0]  load_cnt_r;
  logic [LCW-1:0]  row_r;
  logic [CW-1:0]   col_r;
  logic            col_wrap, row_ok;

  // restoring divider: load_cnt / cols
  logic [LCW-1:0]   div_quo_r, div_quo_nxt;
  logic [DIM_W-1:0] div_rem_r, div_rem_nxt;
  logic [DIVCW-1:0] div_cnt_r;
  logic [DIM_W:0]   div_trial;
  logic             div_ge;

  // clear sweep
  logic [RW-1:0] clr_row_r;
  logic [CW-1:0] clr_col_r;
  logic          clr_col_wrap;

  // search
  logic [RW-1:0]  top_row_r, nb_row_r, nb_row;
  logic [CW-1:0]  top_col_r, nb_col_r, nb_col;
  logic [RW-1:0]  start_row_s;
  logic [CW-1:0]  start_col_s;
  dir_t           dir_r;
  logic           nb_in;
  logic [SDW-1:0] depth_r;

  // memories
  logic [gtr_pkg::KIND_W-1:0] cell_mem [CELLS];
  logic                       vis_mem  [CELLS];
  logic [AW-1:0]              stk_mem  [CELLS];
  logic [gtr_pkg::KIND_W-1:0] cell_rd_r;
  logic                       vis_rd_r;
  logic [AW-1:0]              stk_rd_r;

  logic [AW-1:0] cell_raddr, vis_waddr, stk_waddr, stk_wdata, stk_raddr;
  logic          vis_we, vis_wdata, stk_we;

  // zero counts as one, above the maximum saturates
  always_comb begin
    if (grid_rows_r == '0)
      rows_c = DIM_W'(1);
    else if (XW'(grid_rows_r) > XW'(MAX_ROWS))
      rows_c = DIM_W'(MAX_ROWS);
    else
      rows_c = grid_rows_r;
    if (grid_cols_r == '0)
      cols_c = DIM_W'(1);
    else if (XW'(grid_cols_r) > XW'(MAX_COLS))
      cols_c = DIM_W'(MAX_COLS);
    else
      cols_c = grid_cols_r;
  end

  assign col_wrap = (XW'(col_r) + XW'(1)) == XW'(cols_c);
  assign row_ok   = row_r < LCW'(MAX_ROWS);

  assign div_trial   = {div_rem_r, div_quo_r[LCW-1]};
  assign div_ge      = div_trial >= {1'b0, cols_c};
  assign div_rem_nxt = div_ge ? DIM_W'(div_trial - {1'b0, cols_c}) : DIM_W'(div_trial);
  assign div_quo_nxt = {div_quo_r[LCW-2:0], div_ge};

  assign clr_col_wrap = (XW'(clr_col_r) + XW'(1)) == XW'(cols_c);

  assign start_row_s = (XW'(start_row_r) < XW'(rows_c)) ? RW'(start_row_r)
                                                         : RW'(rows_c - DIM_W'(1));
  assign start_col_s = (XW'(start_col_r) < XW'(cols_c)) ? CW'(start_col_r)
                                                         : CW'(cols_c - DIM_W'(1));

  // neighbor order: right, left, up, down
  always_comb begin
    nb_row = top_row_r;
    nb_col = top_col_r;
    nb_in  = 1'b0;
    unique case (dir_r)
      DIR_RIGHT: begin
        nb_col = top_col_r + CW'(1);
        nb_in  = (XW'(top_col_r) + XW'(1)) < XW'(cols_c);
      end
      DIR_LEFT: begin
        nb_col = top_col_r - CW'(1);
        nb_in  = top_col_r != '0;
      end
      DIR_UP: begin
        nb_row = top_row_r - RW'(1);
        nb_in  = top_row_r != '0;
      end
      DIR_DOWN: begin
        nb_row = top_row_r + RW'(1);
        nb_in  = (XW'(top_row_r) + XW'(1)) < XW'(rows_c);
      end
    endcase
  end

  always_comb begin
    sts.load_last = ({1'b0, load_cnt_r} + (LCW+1)'(1)) >= {1'b0, total_r};
    sts.div_done  = div_cnt_r == DIVCW'(LCW);
    sts.clr_last  = clr_col_wrap && ((XW'(clr_row_r) + XW'(1)) == XW'(rows_c));
    sts.top_treas = cell_rd_r == gtr_pkg::KIND_TREASURE;
    sts.nb_in     = nb_in;
    sts.dir_last  = dir_r == DIR_DOWN;
    sts.nb_vis    = vis_rd_r;
    sts.nb_wall   = cell_rd_r == gtr_pkg::KIND_WALL;
    sts.depth_one = depth_r == SDW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= DIM_W'(1);
      grid_cols_r <= DIM_W'(1);
      start_row_r <= '0;
      start_col_r <= '0;
      total_r     <= LCW'(1);
      load_cnt_r  <= '0;
      row_r       <= '0;
      col_r       <= '0;
      div_quo_r   <= '0;
      div_rem_r   <= '0;
      div_cnt_r   <= '0;
      clr_row_r   <= '0;
      clr_col_r   <= '0;
      top_row_r   <= '0;
      top_col_r   <= '0;
      nb_row_r    <= '0;
      nb_col_r    <= '0;
      dir_r       <= DIR_RIGHT;
      depth_r     <= '0;
    end else begin
      total_r <= LCW'(rows_c * cols_c);

      if (cmd.cfg_wr) begin
        unique case (gtr_pkg::reg_idx_t'(cfg_index))
          gtr_pkg::REG_GRID_ROWS: grid_rows_r <= cfg_data;
          gtr_pkg::REG_GRID_COLS: grid_cols_r <= cfg_data;
          gtr_pkg::REG_START_ROW: start_row_r <= cfg_data[gtr_pkg::START_W-1:0];
          gtr_pkg::REG_START_COL: start_col_r <= cfg_data[gtr_pkg::START_W-1:0];
        endcase
      end

      if (cmd.load) begin
        if (sts.load_last) begin
          load_cnt_r <= '0;
          row_r      <= '0;
          col_r      <= '0;
          clr_row_r  <= '0;
          clr_col_r  <= '0;
        end else begin
          load_cnt_r <= load_cnt_r + LCW'(1);
          if (col_wrap) begin
            col_r <= '0;
            row_r <= row_r + LCW'(1);
          end else begin
            col_r <= col_r + CW'(1);
          end
        end
      end

      if (cmd.div_init) begin
        div_quo_r <= load_cnt_r;
        div_rem_r <= '0;
        div_cnt_r <= '0;
      end else if (cmd.div_step) begin
        div_quo_r <= div_quo_nxt;
        div_rem_r <= div_rem_nxt;
        div_cnt_r <= div_cnt_r + DIVCW'(1);
        if (div_cnt_r == DIVCW'(LCW - 1)) begin
          row_r <= div_quo_nxt;
          col_r <= CW'(div_rem_nxt);
        end
      end

      if (cmd.clr_step) begin
        if (clr_col_wrap) begin
          clr_col_r <= '0;
          clr_row_r <= clr_row_r + RW'(1);
        end else begin
          clr_col_r <= clr_col_r + CW'(1);
        end
      end

      if (cmd.srch_init) begin
        top_row_r <= start_row_s;
        top_col_r <= start_col_s;
        depth_r   <= SDW'(1);
      end
      if (cmd.top_rd)
        dir_r <= DIR_RIGHT;
      else if (cmd.dir_next)
        dir_r <= dir_t'(dir_r + 2'd1);
      if (cmd.nb_rd) begin
        nb_row_r <= nb_row;
        nb_col_r <= nb_col;
      end
      if (cmd.push) begin
        top_row_r <= nb_row_r;
        top_col_r <= nb_col_r;
        depth_r   <= depth_r + SDW'(1);
      end
      if (cmd.pop)
        depth_r <= depth_r - SDW'(1);
      if (cmd.pop_fill)
        {top_row_r, top_col_r} <= stk_rd_r;
    end
  end

  // cell store
  assign cell_raddr = cmd.nb_rd ? {nb_row, nb_col} : {top_row_r, top_col_r};

  always_ff @(posedge clk) begin
    if (cmd.load && row_ok)
      cell_mem[{RW'(row_r), col_r}] <= cell_kind;
    cell_rd_r <= cell_mem[cell_raddr];
  end

  // visited map
  always_comb begin
    vis_we    = cmd.clr_step || cmd.top_rd || cmd.mark_nb;
    vis_wdata = !cmd.clr_step;
    if (cmd.clr_step)
      vis_waddr = {clr_row_r, clr_col_r};
    else if (cmd.mark_nb)
      vis_waddr = {nb_row_r, nb_col_r};
    else
      vis_waddr = {top_row_r, top_col_r};
  end

  always_ff @(posedge clk) begin
    if (vis_we)
      vis_mem[vis_waddr] <= vis_wdata;
    vis_rd_r <= vis_mem[{nb_row, nb_col}];
  end

  // search stack
  assign stk_we    = cmd.srch_init || cmd.push;
  assign stk_waddr = cmd.srch_init ? '0 : depth_r[AW-1:0];
  assign stk_wdata = cmd.srch_init ? {start_row_s, start_col_s} : {nb_row_r, nb_col_r};
  assign stk_raddr = AW'(depth_r - SDW'(2));

  always_ff @(posedge clk) begin
    if (stk_we)
      stk_mem[stk_waddr] <= stk_wdata;
    stk_rd_r <= stk_mem[stk_raddr];
  end

`ifndef SYNTHESIS
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> depth_r < SDW'(CELLS))
    else $error("stack push beyond capacity");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> depth_r != '0)
    else $error("stack pop while empty");
`endif

endmodule

`default_nettype wire

FILE: design/gtr_ctrl.sv
// Controller: sequences load, divider, clear sweep and depth-first search; owns the result register.
`default_nettype none

module gtr_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  output logic               out_valid,
  output logic               out_res,
  input  wire logic          out_tready,
  input  wire gtr_pkg::sts_t sts,
  output gtr_pkg::cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_LOAD,
    S_DIVI,
    S_DIV,
    S_CLEAR,
    S_TOP,
    S_TOPCHK,
    S_NB,
    S_NBCHK,
    S_POP,
    S_POPW
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_res_r, out_res_nxt;

  always_comb begin
    cmd           = '0;
    in_tready     = 1'b0;
    cfg_ready     = 1'b0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_res_nxt   = out_res_r;
    unique case (state_r)
      S_LOAD: begin
        cfg_ready  = 1'b1;
        // a completing cell waits until the previous result is taken
        in_tready  = !cfg_valid && !(out_valid_r && sts.load_last);
        cmd.cfg_wr = cfg_valid;
        cmd.load   = in_tvalid && in_tready;
        if (cfg_valid)
          state_nxt = S_DIVI;
        else if (cmd.load && sts.load_last)
          state_nxt = S_CLEAR;
      end
      S_DIVI: begin
        cmd.div_init = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done)
          state_nxt = S_LOAD;
        else
          cmd.div_step = 1'b1;
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          cmd.srch_init = 1'b1;
          state_nxt     = S_TOP;
        end
      end
      S_TOP: begin
        cmd.top_rd = 1'b1;
        state_nxt  = S_TOPCHK;
      end
      S_TOPCHK: begin
        if (sts.top_treas) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = 1'b1;
          state_nxt     = S_LOAD;
        end else begin
          state_nxt = S_NB;
        end
      end
      S_NB: begin
        if (sts.nb_in) begin
          cmd.nb_rd = 1'b1;
          state_nxt = S_NBCHK;
        end else if (sts.dir_last) begin
          state_nxt = S_POP;
        end else begin
          cmd.dir_next = 1'b1;
        end
      end
      S_NBCHK: begin
        if (!sts.nb_vis && !sts.nb_wall) begin
          cmd.push  = 1'b1;
          state_nxt = S_TOP;
        end else begin
          cmd.mark_nb = sts.nb_wall && !sts.nb_vis;
          if (sts.dir_last) begin
            state_nxt = S_POP;
          end else begin
            cmd.dir_next = 1'b1;
            state_nxt    = S_NB;
          end
        end
      end
      S_POP: begin
        cmd.pop = 1'b1;
        if (sts.depth_one) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = 1'b0;
          state_nxt     = S_LOAD;
        end else begin
          state_nxt = S_POPW;
        end
      end
      S_POPW: begin
        cmd.pop_fill = 1'b1;
        state_nxt    = S_TOP;
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      out_valid_r <= 1'b0;
      out_res_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      out_res_r   <= out_res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

`ifndef SYNTHESIS
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && sts.load_last) |-> !out_valid_r)
    else $error("grid completed while previous result pending");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_TOPCHK || $past(state_r) == S_POP))
    else $error("result raised outside search end");
`endif

endmodule

`default_nettype wire
